@@ sv/ufw_pkg.sv @@
// Shared widths, request kind codes and reset constants for the
// weighted union-find table. No dependencies.
`default_nettype none
package ufw_pkg;

  localparam int KIND_W = 2;
  localparam int ID_W   = 10;
  localparam int CNT_W  = 11;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  localparam kind_t KIND_CONNECT = 2'd0;
  localparam kind_t KIND_QUERY   = 2'd1;
  localparam kind_t KIND_SIZE    = 2'd2;

  localparam int ACTIVE_RST = 1024;

endpackage
`default_nettype wire

@@ sv/union_find_weighted.sv @@
// Weighted quick-union table: parent and size memories, root walks, write-back.
// A flagged id or unused kind is answered from idle without a walk; a size query walks
// the first id to its root, other kinds walk both ids (one parent/size read per hop;
// tree depth is at most log2 of the element count). One item at a time.
// After reset and after each cfg write, a clearing pass rewrites both memories;
// busy is high meanwhile. Results cannot be stalled.
`default_nettype none
module union_find_weighted
  import ufw_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire kind_t            in_kind,
  input  wire id_t              in_first_id,
  input  wire id_t              in_second_id,
  output logic                  out_valid,
  output logic                  out_same_set,
  output id_t                   out_first_root,
  output cnt_t                  out_cluster_size,
  output cnt_t                  out_cluster_count,
  output logic                  out_id_error,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire cnt_t             cfg_data
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ELEMENTS - 1);
  localparam cnt_t EFF_RST = (ACTIVE_RST < MAX_ELEMENTS) ? CNT_W'(ACTIVE_RST)
                                                         : CNT_W'(MAX_ELEMENTS);

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALKP = 2'd2;
  localparam logic [1:0] ST_WALKQ = 2'd3;

  function automatic logic [AW-1:0] to_addr(input id_t id);
    logic [31:0] w;
    w = 32'(id);
    return w[AW-1:0];
  endfunction

  id_t  parent_mem [MAX_ELEMENTS];
  cnt_t size_mem   [MAX_ELEMENTS];

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] sw_r, sw_nxt;
  cnt_t          eff_r, eff_nxt;
  cnt_t          cnt_r, cnt_nxt;
  kind_t         kind_r, kind_nxt;
  id_t           q_r, q_nxt;
  id_t           cur_r, cur_nxt;
  logic          first_r, first_nxt;
  id_t           rp_r, rp_nxt;
  cnt_t          szp_r, szp_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          same_r, same_nxt;
  id_t           froot_r, froot_nxt;
  cnt_t          csize_r, csize_nxt;
  cnt_t          ocnt_r, ocnt_nxt;
  logic          err_r, err_nxt;

  logic [AW-1:0] rd_addr;
  id_t           prd;
  cnt_t          srd;
  logic          pwe, swe;
  logic [AW-1:0] pwaddr, swaddr;
  id_t           pwdata;
  cnt_t          swdata;

  logic          p_bad, q_bad, is_root, diff;
  cnt_t          sum;

  always_ff @(posedge clk) begin
    prd <= parent_mem[rd_addr];
    srd <= size_mem[rd_addr];
    if (pwe) begin
      parent_mem[pwaddr] <= pwdata;
    end
    if (swe) begin
      size_mem[swaddr] <= swdata;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    sw_nxt        = sw_r;
    eff_nxt       = eff_r;
    cnt_nxt       = cnt_r;
    kind_nxt      = kind_r;
    q_nxt         = q_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    rp_nxt        = rp_r;
    szp_nxt       = szp_r;
    out_valid_nxt = 1'b0;
    same_nxt      = same_r;
    froot_nxt     = froot_r;
    csize_nxt     = csize_r;
    ocnt_nxt      = ocnt_r;
    err_nxt       = err_r;
    rd_addr       = to_addr(cur_r);
    pwe           = 1'b0;
    swe           = 1'b0;
    pwaddr        = sw_r;
    swaddr        = sw_r;
    pwdata        = ID_W'(sw_r);
    swdata        = CNT_W'(1);

    p_bad   = {1'b0, in_first_id} >= eff_r;
    q_bad   = {1'b0, in_second_id} >= eff_r;
    is_root = (prd == cur_r);
    diff    = (rp_r != cur_r);
    sum     = szp_r + srd;

    case (state_r)
      ST_SWEEP: begin
        pwe    = 1'b1;
        swe    = 1'b1;
        sw_nxt = sw_r + 1'b1;
        if (sw_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = in_kind;
          q_nxt     = in_second_id;
          cur_nxt   = in_first_id;
          first_nxt = 1'b1;
          rd_addr   = to_addr(in_first_id);
          same_nxt  = 1'b0;
          froot_nxt = '0;
          csize_nxt = '0;
          ocnt_nxt  = cnt_r;
          err_nxt   = 1'b0;
          case (in_kind)
            KIND_CONNECT, KIND_QUERY: begin
              if (p_bad || q_bad) begin
                err_nxt       = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALKP;
              end
            end
            KIND_SIZE: begin
              if (p_bad) begin
                err_nxt       = 1'b1;
                out_valid_nxt = 1'b1;
              end else begin
                state_nxt = ST_WALKP;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_WALKP: begin
        if (is_root) begin
          rp_nxt  = cur_r;
          szp_nxt = srd;
          if (kind_r == KIND_SIZE) begin
            // size only counts when the id itself was a root
            froot_nxt     = cur_r;
            csize_nxt     = first_r ? srd : '0;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cur_nxt   = q_r;
            rd_addr   = to_addr(q_r);
            state_nxt = ST_WALKQ;
          end
        end else begin
          cur_nxt   = prd;
          first_nxt = 1'b0;
          rd_addr   = to_addr(prd);
        end
      end
      ST_WALKQ: begin
        if (is_root) begin
          same_nxt  = !diff;
          froot_nxt = rp_r;
          if (kind_r == KIND_CONNECT && diff) begin
            pwe    = 1'b1;
            swe    = 1'b1;
            swdata = sum;
            if (szp_r < srd) begin
              pwaddr = to_addr(rp_r);
              pwdata = cur_r;
              swaddr = to_addr(cur_r);
            end else begin
              pwaddr = to_addr(cur_r);
              pwdata = rp_r;
              swaddr = to_addr(rp_r);
            end
            if (cnt_r != '0) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          ocnt_nxt      = cnt_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cur_nxt = prd;
          rd_addr = to_addr(prd);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write reloads the count and restarts the clearing pass
    if (cfg_valid) begin
      eff_nxt   = (int'(cfg_data) < MAX_ELEMENTS) ? cfg_data : CNT_W'(MAX_ELEMENTS);
      cnt_nxt   = eff_nxt;
      sw_nxt    = '0;
      state_nxt = ST_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sw_r        <= '0;
      eff_r       <= EFF_RST;
      cnt_r       <= EFF_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      eff_r       <= eff_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    q_r     <= q_nxt;
    cur_r   <= cur_nxt;
    first_r <= first_nxt;
    rp_r    <= rp_nxt;
    szp_r   <= szp_nxt;
    same_r  <= same_nxt;
    froot_r <= froot_nxt;
    csize_r <= csize_nxt;
    ocnt_r  <= ocnt_nxt;
    err_r   <= err_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_same_set      = same_r;
  assign out_first_root    = froot_r;
  assign out_cluster_size  = csize_r;
  assign out_cluster_count = ocnt_r;
  assign out_id_error      = err_r;

endmodule
`default_nettype wire
